@@ hdl/traffic_light_sequencer_unit_assert.svh @@
// assertion macros for the traffic light sequencer core
// no dependencies; include by bare file name at the end of a module
`ifndef TRAFFIC_LIGHT_SEQUENCER_UNIT_ASSERT_SVH
`define TRAFFIC_LIGHT_SEQUENCER_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define TLS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tls assertion failed");

// consequence in the cycle after the condition
`define TLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tls assertion failed");

`endif

@@ hdl/tls_pkg.sv @@
// types, codes and the duty calculation for the traffic light sequencer
// no dependencies
`timescale 1ns / 1ps

package tls_pkg;

    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_RED_HOLD = 2'd1;
    localparam logic [1:0] MODE_BLINK    = 2'd2;
    localparam logic [1:0] MODE_DARK     = 2'd3;

    localparam logic [2:0] PH_RED     = 3'd0;
    localparam logic [2:0] PH_YELLOW1 = 3'd1;
    localparam logic [2:0] PH_GREEN   = 3'd2;
    localparam logic [2:0] PH_FLICKER = 3'd3;
    localparam logic [2:0] PH_YELLOW2 = 3'd4;

    localparam logic [2:0] PAT_OFF    = 3'd0;
    localparam logic [2:0] PAT_RED    = 3'd1;
    localparam logic [2:0] PAT_YELLOW = 3'd2;
    localparam logic [2:0] PAT_GREEN  = 3'd3;
    localparam logic [2:0] PAT_ALL    = 3'd4;

    localparam logic [2:0] FLICKER_TOGGLES = 3'd6;
    localparam logic [8:0] BLINK_PERIOD    = 9'd500;

    localparam logic [1:0] REG_RED     = 2'd0;
    localparam logic [1:0] REG_YELLOW  = 2'd1;
    localparam logic [1:0] REG_GREEN   = 2'd2;
    localparam logic [1:0] REG_FLICKER = 2'd3;

    localparam int FlickerDefault = 1000 / 6;
    localparam logic [15:0] RED_RESET     = 16'd2000;
    localparam logic [15:0] YELLOW_RESET  = 16'd500;
    localparam logic [15:0] GREEN_RESET   = 16'd2000;
    localparam logic [15:0] FLICKER_RESET = 16'(FlickerDefault);

    typedef struct packed {
        logic [15:0] red_time;
        logic [15:0] yellow_time;
        logic [15:0] green_time;
        logic [15:0] flicker_time;
    } t_cfg;

    typedef struct packed {
        logic       tick;
        logic [2:0] levels;   // button three, two, one
        logic [9:0] pot;
    } t_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] yellow;
        logic [7:0] green;
        logic [1:0] mode;
        logic [2:0] phase;
    } t_result;

    // pot*255/1023 truncated: estimate x/1023 as (x + x/1024)/1024, then one correction
    function automatic logic [7:0] f_duty(input logic [9:0] pot);
        logic [17:0] x;
        logic [17:0] q;
        logic [17:0] rem;
        x   = {pot, 8'd0} - {8'd0, pot};
        q   = (x + (x >> 10)) >> 10;
        rem = x - ((q << 10) - q);
        if (rem >= 18'd1023) begin
            q = q + 18'd1;
        end
        return q[7:0];
    endfunction

endpackage

@@ hdl/tls_cfg.sv @@
// duration registers behind the apb-style configuration port
// depends on tls_pkg
`timescale 1ns / 1ps

module tls_cfg
    import tls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_time     <= RED_RESET;
            r_cfg.yellow_time  <= YELLOW_RESET;
            r_cfg.green_time   <= GREEN_RESET;
            r_cfg.flicker_time <= FLICKER_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RED:     r_cfg.red_time     <= pwdata[15:0];
                REG_YELLOW:  r_cfg.yellow_time  <= pwdata[15:0];
                REG_GREEN:   r_cfg.green_time   <= pwdata[15:0];
                REG_FLICKER: r_cfg.flicker_time <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RED:     prdata = {16'd0, r_cfg.red_time};
            REG_YELLOW:  prdata = {16'd0, r_cfg.yellow_time};
            REG_GREEN:   prdata = {16'd0, r_cfg.green_time};
            REG_FLICKER: prdata = {16'd0, r_cfg.flicker_time};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

@@ hdl/tls_core.sv @@
// sequencer state: button edges, phase machine, blinker and lamp rendering
// depends on tls_pkg and traffic_light_sequencer_unit_assert.svh
`timescale 1ns / 1ps

module tls_core
    import tls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [2:0]  r_phase,   n_phase;
    logic [15:0] r_elapsed, n_elapsed;
    logic [2:0]  r_flicker, n_flicker;
    logic [2:0]  r_pattern, n_pattern;
    logic [1:0]  r_mode,    n_mode;
    logic [8:0]  r_blink,   n_blink;
    logic [2:0]  r_last,    n_last;
    logic [7:0]  duty;
    logic        hold_phase;

    assign duty = f_duty(i_item.pot);

    // override mode with no button falling on this edge keeps the phase machine frozen
    assign hold_phase = (r_mode != MODE_NORMAL) && !(i_advance && |(r_last & ~i_item.levels));

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_flicker = r_flicker;
        n_pattern = r_pattern;
        n_mode    = r_mode;
        n_blink   = r_blink;
        n_last    = i_item.levels;

        // falling edges, button one first, each sees the mode left by the previous
        for (int b = 0; b < 3; b++) begin
            if (r_last[b] && !i_item.levels[b]) begin
                if (n_mode != 2'(b + 1)) begin
                    n_mode = 2'(b + 1);
                    case (n_mode)
                        MODE_RED_HOLD: n_pattern = PAT_RED;
                        MODE_BLINK: begin
                            n_pattern = PAT_ALL;
                            n_blink   = '0;
                        end
                        default: n_pattern = PAT_OFF;
                    endcase
                end else begin
                    n_mode    = MODE_NORMAL;
                    n_phase   = PH_RED;
                    n_elapsed = '0;
                end
            end
        end

        if (i_item.tick) begin
            if (n_mode == MODE_NORMAL) begin
                if (n_elapsed != 16'hFFFF) begin
                    n_elapsed = n_elapsed + 16'd1;
                end
                case (n_phase)
                    PH_RED: begin
                        n_pattern = PAT_RED;
                        if (n_elapsed >= i_cfg.red_time) begin
                            n_elapsed = '0;
                            n_phase   = PH_YELLOW1;
                        end
                    end
                    PH_YELLOW1: begin
                        n_pattern = PAT_YELLOW;
                        if (n_elapsed >= i_cfg.yellow_time) begin
                            n_elapsed = '0;
                            n_phase   = PH_GREEN;
                        end
                    end
                    PH_GREEN: begin
                        n_pattern = PAT_GREEN;
                        if (n_elapsed >= i_cfg.green_time) begin
                            n_elapsed = '0;
                            n_phase   = PH_FLICKER;
                            n_flicker = '0;
                        end
                    end
                    PH_FLICKER: begin
                        if (n_elapsed >= i_cfg.flicker_time) begin
                            n_elapsed = '0;
                            n_pattern = (n_pattern == PAT_GREEN) ? PAT_OFF : PAT_GREEN;
                            if (n_flicker != 3'd7) begin
                                n_flicker = n_flicker + 3'd1;
                            end
                            if (n_flicker >= FLICKER_TOGGLES) begin
                                n_phase = PH_YELLOW2;
                            end
                        end
                    end
                    default: begin
                        n_pattern = PAT_YELLOW;
                        if (n_elapsed >= i_cfg.yellow_time) begin
                            n_elapsed = '0;
                            n_phase   = PH_RED;
                        end
                    end
                endcase
            end else if (n_mode == MODE_BLINK) begin
                n_blink = n_blink + 9'd1;
                if (n_blink >= BLINK_PERIOD) begin
                    n_blink   = '0;
                    n_pattern = (n_pattern == PAT_ALL) ? PAT_OFF : PAT_ALL;
                end
            end
        end
    end

    // lamps follow the updated pattern; an all-lamps pattern only lights in blink mode
    always_comb begin
        o_result.red    = 8'd0;
        o_result.yellow = 8'd0;
        o_result.green  = 8'd0;
        o_result.mode   = n_mode;
        o_result.phase  = n_phase;
        if (n_mode == MODE_BLINK) begin
            if (n_pattern == PAT_ALL) begin
                o_result.red    = duty;
                o_result.yellow = duty;
                o_result.green  = duty;
            end
        end else begin
            case (n_pattern)
                PAT_RED:    o_result.red    = duty;
                PAT_YELLOW: o_result.yellow = duty;
                PAT_GREEN:  o_result.green  = duty;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RED;
            r_elapsed <= '0;
            r_flicker <= '0;
            r_pattern <= PAT_OFF;
            r_mode    <= MODE_NORMAL;
            r_blink   <= '0;
            r_last    <= 3'b111;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_flicker <= n_flicker;
            r_pattern <= n_pattern;
            r_mode    <= n_mode;
            r_blink   <= n_blink;
            r_last    <= n_last;
        end
    end

`include "traffic_light_sequencer_unit_assert.svh"

    `TLS_ASSERT_SAME(a_flicker_bound, i_clk, i_rst_n, 1'b1, r_flicker <= FLICKER_TOGGLES)
    `TLS_ASSERT_SAME(a_blink_bound, i_clk, i_rst_n, 1'b1, r_blink < BLINK_PERIOD)
    `TLS_ASSERT_NEXT(a_frozen_phase, i_clk, i_rst_n, hold_phase, $stable(r_phase) && $stable(r_elapsed))

endmodule

@@ hdl/traffic_light_sequencer_unit.sv @@
// channel   direction  handshake            payload
// item      in         i_valid / o_stall    i_tick, i_button_*_level, i_pot_level
// result    out        o_valid / i_stall    o_*_level, o_mode_code, o_phase_code
// config    in         psel/penable/pwrite  paddr, pwdata, prdata, pready
// one item per cycle unless stalled; items pass the input, then the output register
// the sequencer state is updated between input and output registers, when a result is registered
// synchronous active-low reset, no clearing pass; durations return to their defaults
// a stalled result holds the output register, and the input register fills behind it
// top level; depends on tls_pkg, tls_cfg and tls_core
`timescale 1ns / 1ps

module traffic_light_sequencer_unit
    import tls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_tick,
    input  logic        i_button_one_level,
    input  logic        i_button_two_level,
    input  logic        i_button_three_level,
    input  logic [9:0]  i_pot_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_level,
    output logic [7:0]  o_yellow_level,
    output logic [7:0]  o_green_level,
    output logic [1:0]  o_mode_code,
    output logic [2:0]  o_phase_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_result result;
    t_item   r_item;
    t_result r_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;
    logic    load;

    // the output slot frees when empty or when its result is taken this edge
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign load    = i_valid && !o_stall;

    tls_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tls_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.tick   <= i_tick;
            r_item.levels <= {i_button_three_level, i_button_two_level, i_button_one_level};
            r_item.pot    <= i_pot_level;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red_level    = r_result.red;
    assign o_yellow_level = r_result.yellow;
    assign o_green_level  = r_result.green;
    assign o_mode_code    = r_result.mode;
    assign o_phase_code   = r_result.phase;

endmodule
